// ----- rtl/core/lzwd_pkg.sv -----
`default_nettype none
package lzwd_pkg;

   localparam int WIN_AW    = 12;
   localparam int WIN_DEPTH = 1 << WIN_AW;
   localparam int FILL_W    = WIN_AW + 1;
   localparam int LEN_BASE  = 3;
   localparam int LEN_W     = 5;
   localparam int CNT_W     = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DW    = 32;

   localparam logic [WIN_AW-1:0] WP_START = 12'hFEE;

   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_INPUT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_LIMIT = 1'd1;

   typedef struct packed {
      logic [7:0] comp_byte;
      logic       end_of_stream;
   } lzwd_req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             run_last;
      logic [CNT_W-1:0] produced_count;
   } lzwd_rsp_type;

endpackage
`default_nettype wire

// ----- rtl/core/lzss_window_decompressor.sv -----
// output: a literal under the output limit is registered onto rsp in the cycle after its
// request; match bytes pass mem_q_ff then rsp, one per cycle while rsp is not stalled
// throughput: one request per cycle for flag, literal and first match bytes while rsp
// is not stalled; a match holds req_stall until its last byte has been produced
// reset: synchronous, active high; the window needs no clearing pass, entries not yet
// written in the current stream read as zero through a fill count
`default_nettype none
module lzss_window_decompressor
   import lzwd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire lzwd_req_type         req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output lzwd_rsp_type              rsp_payload,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DW-1:0]    csr_wdata
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MATCH = 1'b1;

   logic [7:0] window_mem [WIN_DEPTH];
   logic [7:0] mem_q_ff;

   logic              state_ff, state_in;
   logic [WIN_AW-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [8:0]        flags_ff, flags_in;
   logic [7:0]        pend_ff, pend_in;
   logic              await_ff, await_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              eos_ff, eos_in;
   logic [WIN_AW-1:0] rd_addr_ff, rd_addr_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              fwd_ff, fwd_in;
   logic [7:0]        fwd_data_ff, fwd_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lzwd_rsp_type      rsp_data_ff, rsp_data_in;
   logic              invert_ff;
   logic [CNT_W-1:0]  limit_ff;

   logic              slot_free, accept, room, stop, clear;
   logic [7:0]        b, match_data, mem_wdata;
   logic [CNT_W-1:0]  cnt_inc;
   logic [WIN_AW-1:0] off, next_addr, mem_raddr;
   logic              mem_we, mem_re;

   function automatic logic in_window(input logic [WIN_AW-1:0] addr,
                                      input logic [FILL_W-1:0] fill);
      logic [WIN_AW-1:0] span;
      span = addr - WP_START;
      return fill[FILL_W-1] || ({1'b0, span} < fill);
   endfunction

   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = !((state_ff == ST_IDLE) && slot_free);
   assign accept      = req_valid && !req_stall;
   assign b           = req_payload.comp_byte ^ {8{invert_ff}};
   assign room        = count_ff < limit_ff;
   assign cnt_inc     = count_ff + 32'd1;
   assign match_data  = fwd_ff ? fwd_data_ff : (rd_ok_ff ? mem_q_ff : 8'd0);
   assign next_addr   = rd_addr_ff + 12'd1;
   assign off         = {b[7:4], pend_ff};
   assign stop        = (remain_ff == '0) || (cnt_inc == limit_ff);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      flags_in     = flags_ff;
      pend_in      = pend_ff;
      await_in     = await_ff;
      count_in     = count_ff;
      eos_in       = eos_ff;
      rd_addr_in   = rd_addr_ff;
      remain_in    = remain_ff;
      rd_ok_in     = rd_ok_ff;
      fwd_in       = fwd_ff;
      fwd_data_in  = fwd_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = rd_addr_ff;
      mem_wdata    = b;
      clear        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (await_ff) begin
                  await_in = 1'b0;
                  flags_in = flags_ff >> 1;
                  if (room) begin
                     mem_re     = 1'b1;
                     mem_raddr  = off;
                     rd_addr_in = off;
                     remain_in  = {1'b0, b[3:0]} + LEN_W'(LEN_BASE - 1);
                     rd_ok_in   = in_window(off, fill_ff);
                     fwd_in     = 1'b0;
                     eos_in     = req_payload.end_of_stream;
                     state_in   = ST_MATCH;
                  end else begin
                     clear = req_payload.end_of_stream;
                  end
               end else if (flags_ff < 9'd2) begin
                  flags_in = {1'b1, b};
                  clear    = req_payload.end_of_stream;
               end else if (flags_ff[0]) begin
                  flags_in = flags_ff >> 1;
                  if (room) begin
                     mem_we       = 1'b1;
                     wp_in        = wp_ff + 12'd1;
                     fill_in      = fill_ff[FILL_W-1] ? fill_ff : fill_ff + 13'd1;
                     count_in     = cnt_inc;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{out_byte: b, run_last: 1'b1, produced_count: cnt_inc};
                  end
                  clear = req_payload.end_of_stream;
               end else begin
                  pend_in  = b;
                  await_in = 1'b1;
                  clear    = req_payload.end_of_stream;
               end
            end
         end
         ST_MATCH: begin
            if (slot_free) begin
               mem_we       = 1'b1;
               mem_wdata    = match_data;
               wp_in        = wp_ff + 12'd1;
               fill_in      = fill_ff[FILL_W-1] ? fill_ff : fill_ff + 13'd1;
               count_in     = cnt_inc;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: match_data, run_last: stop, produced_count: cnt_inc};
               if (!stop) begin
                  mem_re      = 1'b1;
                  mem_raddr   = next_addr;
                  rd_addr_in  = next_addr;
                  remain_in   = remain_ff - 5'd1;
                  fwd_in      = (next_addr == wp_ff);
                  fwd_data_in = match_data;
                  rd_ok_in    = in_window(next_addr, fill_ff);
               end else begin
                  state_in = ST_IDLE;
                  clear    = eos_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (clear) begin
         wp_in    = WP_START;
         fill_in  = '0;
         flags_in = '0;
         pend_in  = '0;
         await_in = 1'b0;
         count_in = '0;
      end
   end

   // window memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[wp_ff] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= window_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= WP_START;
         fill_ff      <= '0;
         flags_ff     <= '0;
         pend_ff      <= '0;
         await_ff     <= 1'b0;
         count_ff     <= '0;
         eos_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         flags_ff     <= flags_in;
         pend_ff      <= pend_in;
         await_ff     <= await_in;
         count_ff     <= count_in;
         eos_ff       <= eos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      remain_ff   <= remain_in;
      rd_ok_ff    <= rd_ok_in;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= fwd_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= 1'b1;
         limit_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INVERT_INPUT: invert_ff <= csr_wdata[0];
            CSR_OUTPUT_LIMIT: limit_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/lzwd_checker.sv -----
`default_nettype none
module lzwd_checker
   import lzwd_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire lzwd_req_type         req_payload,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire lzwd_rsp_type         rsp_payload,
   input wire logic                 csr_we,
   input wire logic [CSR_IDX_W-1:0] csr_index,
   input wire logic [CSR_DW-1:0]    csr_wdata
);

   // a waiting result is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a match keeps requests back until its last byte has gone
   a_match_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.run_last |-> req_stall)
      else $error("request taken in the middle of a match");

   // every result counts itself
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.produced_count != 32'd0)
      else $error("result with zero count");

   // a request is only taken when the result register can move
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !(rsp_valid && rsp_stall))
      else $error("request taken while result is stalled");

endmodule

bind lzss_window_decompressor lzwd_checker u_lzwd_checker (.*);
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
module tb;
   import lzwd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 280;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lzwd_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lzwd_rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   lzss_window_decompressor uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state as the block should hold it
   logic [7:0] win [0:WIN_DEPTH-1];
   logic [WIN_AW-1:0] wr_ptr;
   logic [8:0] tok_bits;
   logic [7:0] match_low;
   bit match_pending;
   logic [CNT_W-1:0] produced;
   bit inv_on;
   logic [CNT_W-1:0] out_limit;

   lzwd_rsp_type decoded_q[$];
   int mismatches = 0;
   int items_sent = 0;
   bit quiet = 1'b0;
   bit rsp_taken = 1'b0;
   int rsp_hold = 0;

   function automatic void restart_stream();
      for (int i = 0; i < WIN_DEPTH; i++)
         win[i] = 8'h00;
      wr_ptr = WP_START;
      tok_bits = '0;
      match_low = '0;
      match_pending = 1'b0;
      produced = '0;
   endfunction

   function automatic void emit_byte(logic [7:0] v);
      lzwd_rsp_type r;
      if (produced >= out_limit)
         return;
      win[wr_ptr] = v;
      wr_ptr = wr_ptr + WIN_AW'(1);
      produced = produced + 1;
      r.out_byte = v;
      r.run_last = 1'b0;
      r.produced_count = produced;
      decoded_q.insert(decoded_q.size(), r);
   endfunction

   function automatic void decode_request(lzwd_req_type rq);
      logic [7:0] b;
      logic [WIN_AW-1:0] off;
      int len;
      int n_before;
      lzwd_rsp_type r;
      b = rq.comp_byte ^ {8{inv_on}};
      n_before = decoded_q.size();
      if (match_pending) begin
         off = {b[7:4], match_low};
         len = int'(b[3:0]) + LEN_BASE;
         for (int i = 0; i < len; i++)
            emit_byte(win[off + WIN_AW'(i)]);
         match_pending = 1'b0;
         tok_bits = tok_bits >> 1;
      end else if (tok_bits < 9'd2) begin
         tok_bits = {1'b1, b};
      end else if (tok_bits[0]) begin
         emit_byte(b);
         tok_bits = tok_bits >> 1;
      end else begin
         match_low = b;
         match_pending = 1'b1;
      end
      if (decoded_q.size() > n_before) begin
         r = decoded_q[decoded_q.size() - 1];
         r.run_last = 1'b1;
         decoded_q[decoded_q.size() - 1] = r;
      end
      if (rq.end_of_stream)
         restart_stream();
   endfunction

   task automatic send_item(input logic [7:0] b, input logic eos);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{comp_byte: b, end_of_stream: eos};
      do @(posedge clock); while (req_stall);
      decode_request(req_payload);
      items_sent++;
   endtask

   // takes the decoded byte and scrambles it as the current setting wants
   task automatic send_coded(input logic [7:0] d, input logic eos);
      send_item(d ^ {8{inv_on}}, eos);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DW-1:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_INVERT_INPUT)
         inv_on = v[0];
      else if (idx == CSR_OUTPUT_LIMIT)
         out_limit = v;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decoded_q.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic check_output(input lzwd_rsp_type got);
      lzwd_rsp_type want;
      if (decoded_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected output: byte %h last %b count %0d",
                     got.out_byte, got.run_last, got.produced_count);
         return;
      end
      want = decoded_q.pop_front();
      if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
          got.produced_count !== want.produced_count) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected byte %h last %b count %0d, got byte %h last %b count %0d",
                     want.out_byte, want.run_last, want.produced_count,
                     got.out_byte, got.run_last, got.produced_count);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_taken = 1'b1;
         check_output(rsp_payload);
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_hold = quiet ? 0 : $urandom_range(0, 12);
      end
      rsp_stall <= (rsp_hold != 0);
      if (rsp_hold != 0)
         rsp_hold--;
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb: FAIL");
      $finish;
   end

   task automatic test_reset_defaults();
      // inverted input and a zero limit: nothing comes out
      send_coded(8'hFF, 1'b0);
      send_coded(8'h3C, 1'b1);
      wait_idle();
   endtask

   task automatic test_literals_and_matches();
      csr_write(CSR_INVERT_INPUT, 32'd0);
      csr_write(CSR_OUTPUT_LIMIT, 32'hFFFF_FFFF);
      send_coded(8'h13, 1'b0);
      send_coded(8'h00, 1'b0);
      send_coded(8'hFF, 1'b0);
      // overlapping match from the start pointer
      send_coded(8'hEE, 1'b0);
      send_coded(8'hF0, 1'b0);
      // top offset, longest length, wraps around the window
      send_coded(8'hFF, 1'b0);
      send_coded(8'hFF, 1'b0);
      send_coded(8'hA5, 1'b0);
      // half a match at end of stream is dropped
      send_coded(8'h12, 1'b1);
      wait_idle();
   endtask

   task automatic test_inverted_stream();
      csr_write(CSR_INVERT_INPUT, 32'd1);
      send_coded(8'h05, 1'b0);
      send_coded(8'h7E, 1'b0);
      // run-length style match of the byte just written
      send_coded(8'hEE, 1'b0);
      send_coded(8'hF9, 1'b0);
      send_coded(8'h81, 1'b1);
      wait_idle();
   endtask

   task automatic test_output_limit();
      csr_write(CSR_INVERT_INPUT, 32'd0);
      csr_write(CSR_OUTPUT_LIMIT, 32'd4);
      send_coded(8'hFD, 1'b0);
      send_coded(8'h5A, 1'b0);
      send_coded(8'hEE, 1'b0);
      send_coded(8'hFF, 1'b0);
      send_coded(8'h11, 1'b0);
      send_coded(8'h22, 1'b1);
      wait_idle();
      csr_write(CSR_OUTPUT_LIMIT, 32'd0);
      send_coded(8'hFF, 1'b0);
      send_coded(8'h44, 1'b1);
      wait_idle();
      csr_write(CSR_OUTPUT_LIMIT, 32'hFFFF_FFFF);
      // end of stream on a flag byte
      send_coded(8'h00, 1'b1);
      send_coded(8'hFF, 1'b0);
      send_coded(8'h33, 1'b1);
      wait_idle();
   endtask

   task automatic random_config();
      csr_write(CSR_INVERT_INPUT, 32'($urandom_range(0, 1)));
      case ($urandom_range(0, 5))
         0: csr_write(CSR_OUTPUT_LIMIT, 32'd0);
         1, 2: csr_write(CSR_OUTPUT_LIMIT, 32'($urandom_range(1, 40)));
         3: csr_write(CSR_OUTPUT_LIMIT, 32'hFFFF_FFFF);
         default: csr_write(CSR_OUTPUT_LIMIT, $urandom);
      endcase
   endtask

   task automatic random_stream(input int n_tokens);
      logic [7:0] flags;
      logic [WIN_AW-1:0] off;
      bit cut;
      bit last;
      cut = ($urandom_range(0, 4) == 0);
      flags = '0;
      for (int t = 0; t < n_tokens; t++) begin
         last = (t == n_tokens - 1);
         if (t % 8 == 0) begin
            flags = 8'($urandom);
            send_coded(flags, 1'b0);
         end
         if (flags[t % 8]) begin
            send_coded(8'($urandom), last);
         end else begin
            if ($urandom_range(0, 3) == 0)
               off = WIN_AW'($urandom);
            else
               off = wr_ptr - WIN_AW'($urandom_range(1, 24));
            send_coded(off[7:0], last && cut);
            if (!(last && cut))
               send_coded({off[11:8], 4'($urandom)}, last);
         end
      end
   endtask

   task automatic random_noise(input int n);
      for (int i = 0; i < n; i++)
         send_item(8'($urandom), ($urandom_range(0, 19) == 0));
   endtask

   task automatic test_random_streams();
      int start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            wait_idle();
            random_config();
         end
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0)
            random_noise($urandom_range(1, 12));
         else
            random_stream($urandom_range(1, 40));
      end
      quiet = 1'b0;
   endtask

   initial begin
      inv_on = 1'b1;
      out_limit = '0;
      restart_stream();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_literals_and_matches();
      test_inverted_stream();
      test_output_limit();
      test_random_streams();
      wait_idle();
      if (decoded_q.size() != 0) begin
         mismatches += decoded_q.size();
         $display("missing %0d output bytes", decoded_q.size());
      end
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/lzwd_pkg.sv
rtl/core/lzss_window_decompressor.sv
rtl/core/lzwd_checker.sv
tb/tb.sv
